/* rtl/core/assert_macros.svh */
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/core/pvp_pkg.sv */
// shared constants and types of the partition vote proposer
package pvp_pkg;

  localparam int VERTICES   = 4096;
  localparam int PARTITIONS = 16;
  localparam int LANES      = 16;

  localparam int ADDR_W  = $clog2(VERTICES);
  localparam int PART_W  = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int LANE_W  = $clog2(LANES + 1);
  localparam int SLOTS   = PARTITIONS * PARTITIONS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = 13;
  localparam int PROP_W  = 12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_CHUNK = 1'b1;

  typedef struct packed {
    logic              inc;
    logic [PART_W-1:0] inc_idx;
    logic              clear;
    logic [PART_W-1:0] rd_idx;
  } cnt_ctrl_t;

endpackage

/* rtl/core/pvp_in_if.sv */
// input channel: partition loads and adjacency chunks
interface pvp_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] vertex_index;
  logic [3:0]  vertex_partition;
  logic [11:0] source_vertex;
  logic [3:0]  home_partition;
  logic [11:0] column_base;
  logic [15:0] adjacency_bits;
  logic        last_chunk;

  modport source (
    output valid, kind, vertex_index, vertex_partition, source_vertex,
           home_partition, column_base, adjacency_bits, last_chunk,
    input  ready
  );
  modport sink (
    input  valid, kind, vertex_index, vertex_partition, source_vertex,
           home_partition, column_base, adjacency_bits, last_chunk,
    output ready
  );
endinterface

/* rtl/core/pvp_out_if.sv */
// output channel: move proposals
interface pvp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] vertex_id;
  logic [3:0]  chosen_partition;
  logic [11:0] move_number;

  modport source (output valid, vertex_id, chosen_partition, move_number, input ready);
  modport sink   (input valid, vertex_id, chosen_partition, move_number, output ready);
endinterface

/* rtl/core/pvp_counts.sv */
// per-partition neighbor counters with saturating increment and clear
module pvp_counts (
  input  logic                                clk,
  input  logic                                rst,
  input  pvp_pkg::cnt_ctrl_t                  ctrl,
  output logic [pvp_pkg::COUNT_W-1:0]         rd_data
);

  logic [pvp_pkg::COUNT_W-1:0] cnt [pvp_pkg::PARTITIONS];

  assign rd_data = cnt[ctrl.rd_idx];

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < pvp_pkg::PARTITIONS; i++) begin
        cnt[i] <= '0;
      end
    end else if (ctrl.inc && cnt[ctrl.inc_idx] != pvp_pkg::COUNT_MAX) begin
      cnt[ctrl.inc_idx] <= cnt[ctrl.inc_idx] + 1'b1;
    end
  end

endmodule

/* rtl/core/partition_vote_proposer.sv */
// top level of the partition vote proposer
//
// chunk carries two transaction kinds. a load writes one vertex partition
// into the table. an adjacency chunk walks its lanes one column per cycle
// through the single read port of the partition table, so it holds the block
// until its lane walk ends.
// the last chunk of a row then scans the PARTITIONS neighbor counters one per
// cycle, reads the proposal counter memory and loads the output register,
// which raises proposal.valid.
// chunk.ready is high only while idle; a proposal waiting in the output
// register does not block new transactions, but the next proposal waits until
// proposal.ready takes the current one, holding its payload stable.
// reset clears the control state, the neighbor counters and the valid bits of
// the proposal counters (all counters read as zero at once, no clearing pass);
// the partition table holds garbage until written.
module partition_vote_proposer (
  input  logic      clk,
  input  logic      rst,
  pvp_in_if.sink    chunk,
  pvp_out_if.source proposal
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LANE  = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PREAD = 3'd4;
  localparam logic [2:0] S_PWAIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  logic [pvp_pkg::LANE_W-1:0]  lane;
  logic [pvp_pkg::PART_W-1:0]  pt;
  logic [11:0]                 src;
  logic [pvp_pkg::PART_W-1:0]  home;
  logic [11:0]                 base;
  logic [15:0]                 bits;
  logic                        last;
  logic [pvp_pkg::PART_W-1:0]  best;
  logic [pvp_pkg::COUNT_W-1:0] top;
  logic [pvp_pkg::SLOT_W-1:0]  slot;

  logic [3:0] tbl_mem [pvp_pkg::VERTICES];
  logic [3:0] tbl_rdata;
  logic       rd_v;

  logic [pvp_pkg::PROP_W-1:0] prop_mem [pvp_pkg::SLOTS];
  logic [pvp_pkg::SLOTS-1:0]  prop_vld;
  logic [pvp_pkg::PROP_W-1:0] prop_rdata;
  logic                       prop_hit;

  pvp_pkg::cnt_ctrl_t          cnt_ctrl;
  logic [pvp_pkg::COUNT_W-1:0] cnt_rd;

  logic                        in_acc;
  logic                        lane_end;
  logic [12:0]                 lane_col;
  logic                        lane_bit;
  logic                        lane_rd;
  logic                        part_ok;
  logic                        fire;
  logic [pvp_pkg::PART_W-1:0]  home_clamp;
  logic [pvp_pkg::PROP_W-1:0]  prop_cur;

  assign chunk.ready = (state == S_IDLE);
  assign in_acc      = chunk.valid && chunk.ready;

  assign home_clamp = (32'(chunk.home_partition) >= pvp_pkg::PARTITIONS) ?
                      pvp_pkg::PART_W'(pvp_pkg::PARTITIONS - 1) :
                      pvp_pkg::PART_W'(chunk.home_partition);

  assign lane_end = (32'(lane) == pvp_pkg::LANES);
  assign lane_col = {1'b0, base} + 13'(lane);
  assign lane_bit = (32'(lane) < 16) ? bits[4'(lane)] : 1'b0;
  assign lane_rd  = (state == S_LANE) && !lane_end && lane_bit &&
                    (32'(lane_col) < pvp_pkg::VERTICES);
  assign part_ok  = (32'(tbl_rdata) < pvp_pkg::PARTITIONS);

  assign fire     = (state == S_PWAIT) && (!proposal.valid || proposal.ready);
  assign prop_cur = prop_hit ? prop_rdata : '0;

  always_comb begin
    cnt_ctrl.inc     = (state == S_LANE) && rd_v && part_ok;
    cnt_ctrl.inc_idx = pvp_pkg::PART_W'(tbl_rdata);
    cnt_ctrl.clear   = fire;
    case (state)
      S_INIT:  cnt_ctrl.rd_idx = home;
      S_SCAN:  cnt_ctrl.rd_idx = pt;
      default: cnt_ctrl.rd_idx = home;
    endcase
  end

  pvp_counts u_counts (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cnt_ctrl),
    .rd_data (cnt_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_acc && chunk.kind == pvp_pkg::KIND_CHUNK) state_next = S_LANE;
      end
      S_LANE: begin
        if (lane_end) state_next = last ? S_INIT : S_IDLE;
      end
      S_INIT: state_next = S_SCAN;
      S_SCAN: begin
        if (32'(pt) == pvp_pkg::PARTITIONS - 1) state_next = S_PREAD;
      end
      S_PREAD: state_next = S_PWAIT;
      S_PWAIT: begin
        if (fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      rd_v           <= 1'b0;
      prop_vld       <= '0;
      proposal.valid <= 1'b0;
    end else begin
      state <= state_next;
      rd_v  <= lane_rd;
      if (fire) begin
        proposal.valid  <= 1'b1;
        prop_vld[slot]  <= 1'b1;
      end else if (proposal.ready) begin
        proposal.valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && chunk.kind == pvp_pkg::KIND_CHUNK) begin
      src  <= chunk.source_vertex;
      home <= home_clamp;
      base <= chunk.column_base;
      bits <= chunk.adjacency_bits;
      last <= chunk.last_chunk;
      lane <= '0;
    end else if (state == S_LANE) begin
      lane <= lane + 1'b1;
    end
    case (state)
      S_INIT: begin
        top  <= cnt_rd;
        best <= home;
        pt   <= '0;
      end
      S_SCAN: begin
        if (cnt_rd > top) begin
          top  <= cnt_rd;
          best <= pt;
        end
        pt <= pt + 1'b1;
      end
      S_PREAD: begin
        slot <= pvp_pkg::SLOT_W'(32'(home) * pvp_pkg::PARTITIONS + 32'(best));
      end
      default: ;
    endcase
    if (fire) begin
      proposal.vertex_id        <= src;
      proposal.chosen_partition <= 4'(best);
      proposal.move_number      <= prop_cur;
    end
  end

  // vertex partition table
  always_ff @(posedge clk) begin
    if (in_acc && chunk.kind == pvp_pkg::KIND_LOAD &&
        32'(chunk.vertex_index) < pvp_pkg::VERTICES) begin
      tbl_mem[pvp_pkg::ADDR_W'(chunk.vertex_index)] <= chunk.vertex_partition;
    end
    if (lane_rd) begin
      tbl_rdata <= tbl_mem[pvp_pkg::ADDR_W'(lane_col)];
    end
  end

  // proposal counter memory
  always_ff @(posedge clk) begin
    if (state == S_PWAIT && fire) begin
      prop_mem[slot] <= prop_cur + 1'b1;
    end
    if (state == S_PREAD) begin
      prop_rdata <= prop_mem[pvp_pkg::SLOT_W'(32'(home) * pvp_pkg::PARTITIONS +
                                              32'(best))];
      prop_hit   <= prop_vld[pvp_pkg::SLOT_W'(32'(home) * pvp_pkg::PARTITIONS +
                                              32'(best))];
    end
  end

endmodule

/* rtl/core/pvp_checker.sv */
// port-level checker for the partition vote proposer, bound to the top level
`include "assert_macros.svh"

module pvp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_vertex_id,
  input logic [3:0]  out_chosen,
  input logic [11:0] out_number
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled proposal holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_vertex_id) && $stable(out_chosen) && $stable(out_number))

  // a load transaction never produces a proposal
  `ASSERT_NEXT(a_load_silent, clk, rst, in_acc && in_kind == pvp_pkg::KIND_LOAD,
    !$rose(out_valid))

  // a chunk occupies the lane walk, so input is blocked next cycle
  `ASSERT_NEXT(a_chunk_busy, clk, rst, in_acc && in_kind == pvp_pkg::KIND_CHUNK,
    !in_ready)

  // chosen partition is a real partition
  `ASSERT_IMPLIES(a_chosen_range, clk, rst, out_valid,
    32'(out_chosen) < pvp_pkg::PARTITIONS)

endmodule

bind partition_vote_proposer pvp_checker u_pvp_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (chunk.valid),
  .in_ready      (chunk.ready),
  .in_kind       (chunk.kind),
  .out_valid     (proposal.valid),
  .out_ready     (proposal.ready),
  .out_vertex_id (proposal.vertex_id),
  .out_chosen    (proposal.chosen_partition),
  .out_number    (proposal.move_number)
);
